// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared codes and constants of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Request modes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_PUT    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_REFUSED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Slot states
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // Field widths fixed by the interface
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 11;
    localparam int CFG_W    = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    // Mixer multipliers
    localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

endpackage

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing and tombstones.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_stall   i_mode, i_key, i_value
//   out      from block o_out_valid / i_out_stall o_status, o_value_out,
//                                                 o_live_count
//   cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_data (capacity_log2)
//
// Front: the key mixer forms 6 partial products on one 32x32 multiplier per
// item; a clear skips the mixer. Back: each probed slot takes one registered
// memory read (S_READ, then S_CHECK); items overlap front and back.
// A clear, and reset, sweep all MAX_SLOTS slots, one per cycle, before the
// next item is probed. A stalled result holds the back; the front keeps
// hashing into a two-entry queue. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top import lpht_pkg::*; #(
    parameter int MAX_SLOTS  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [VALUE_BITS-1:0] o_value_out,
    output logic [LIVE_W-1:0]     o_live_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int QW = MODE_W + KEY_W + VALUE_BITS + AW;

    logic [CFG_W-1:0] r_cap_log2;
    logic             push, full, pop, q_valid;
    logic [QW-1:0]    f_data, q_data;

    // Capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_log2 <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cap_log2 <= i_cfg_data;
        end
    end

    lpht_front #(.AW(AW), .VB(VALUE_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_key      (i_key),
        .i_value    (i_value),
        .o_push     (push),
        .i_full     (full),
        .o_data     (f_data)
    );

    lpht_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    lpht_back #(.MAX_SLOTS(MAX_SLOTS), .AW(AW), .VB(VALUE_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap_log2   (r_cap_log2),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_value_out  (o_value_out),
        .o_live_count (o_live_count)
    );

endmodule

// ===== rtl/core/lpht_queue.sv =====
// ----------------------------------------------------------------------------
// lpht_queue
// Two-entry request queue between the hashing front and the probing back.
// ----------------------------------------------------------------------------
module lpht_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_buf [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/lpht_front.sv =====
// ----------------------------------------------------------------------------
// lpht_front
// Accepts items and computes the home slot with a 64-bit mixer built from
// one 32x32 multiplier, three partial products per 64-bit product.
// ----------------------------------------------------------------------------
module lpht_front import lpht_pkg::*; #(
    parameter int AW = 10,
    parameter int VB = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VB-1:0]     i_value,
    output logic              o_push,
    input  logic              i_full,
    output logic [MODE_W+KEY_W+VB+AW-1:0] o_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        r_st, n_st;
    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [VB-1:0]     r_value;
    logic [63:0]       r_opa, n_opa;
    logic [63:0]       r_acc, n_acc;
    logic [1:0]        r_ph, n_ph;
    logic              r_rnd, n_rnd;
    logic [AW-1:0]     r_home, n_home;
    logic [63:0]       mul_b;
    logic [31:0]       m_a, m_b;
    logic [63:0]       prod;

    assign o_in_stall = (r_st != F_IDLE);
    assign o_push     = (r_st == F_PUSH);
    assign o_data     = {r_mode, r_key, r_value, r_home};

    // Select partial product operands
    assign mul_b = r_rnd ? MIX_C2 : MIX_C1;
    always_comb begin
        unique case (r_ph)
            2'd0:    begin m_a = r_opa[31:0];  m_b = mul_b[31:0];  end
            2'd1:    begin m_a = r_opa[31:0];  m_b = mul_b[63:32]; end
            default: begin m_a = r_opa[63:32]; m_b = mul_b[31:0];  end
        endcase
    end
    assign prod = 64'(m_a) * 64'(m_b);

    // Sequence the mixer
    always_comb begin
        n_st   = r_st;
        n_opa  = r_opa;
        n_acc  = r_acc;
        n_ph   = r_ph;
        n_rnd  = r_rnd;
        n_home = r_home;
        unique case (r_st)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_opa = i_key ^ (i_key >> 30);
                    n_ph  = 2'd0;
                    n_rnd = 1'b0;
                    n_home = '0;
                    n_st  = (i_mode == MODE_CLEAR) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                if (r_ph == 2'd0) n_acc = prod;
                else              n_acc = r_acc + {prod[31:0], 32'd0};
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    if (!r_rnd) begin
                        n_opa = n_acc ^ (n_acc >> 27);
                        n_rnd = 1'b1;
                    end else begin
                        n_home = AW'(n_acc ^ (n_acc >> 31));
                        n_st   = F_PUSH;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            F_PUSH: begin
                if (!i_full) n_st = F_IDLE;
            end
            default: n_st = F_IDLE;
        endcase
    end

    // Hold payload and mixer state
    always_ff @(posedge i_clk) begin
        if (r_st == F_IDLE && i_in_valid) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        r_opa  <= n_opa;
        r_acc  <= n_acc;
        r_home <= n_home;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= F_IDLE;
            r_ph  <= 2'd0;
            r_rnd <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_ph  <= n_ph;
            r_rnd <= n_rnd;
        end
    end

endmodule

// ===== rtl/core/lpht_back.sv =====
// ----------------------------------------------------------------------------
// lpht_back
// Probes the slot memory one slot per read, updates it, holds the result.
// ----------------------------------------------------------------------------
module lpht_back import lpht_pkg::*; #(
    parameter int MAX_SLOTS = 1024,
    parameter int AW = 10,
    parameter int VB = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CFG_W-1:0]    i_cap_log2,
    input  logic                i_q_valid,
    input  logic [MODE_W+KEY_W+VB+AW-1:0] i_q_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [VB-1:0]       o_value_out,
    output logic [LIVE_W-1:0]   o_live_count
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int RW = 2 + KEY_W + VB;

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [RW-1:0] r_mem [MAX_SLOTS];
    logic [RW-1:0] r_rd;

    logic [1:0]          r_st, n_st;
    logic [AW-1:0]       r_sw, n_sw;
    logic                r_sw_emit, n_sw_emit;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [VB-1:0]       r_val, n_val;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW:0]         r_i, n_i;
    logic                r_has_tomb, n_has_tomb;
    logic [AW-1:0]       r_tomb, n_tomb;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VB-1:0]       r_vout, n_vout;

    logic [MODE_W-1:0] q_mode;
    logic [KEY_W-1:0]  q_key;
    logic [VB-1:0]     q_val;
    logic [AW-1:0]     q_home;
    logic [CFG_W-1:0]  lg;
    logic [16:0]       pow;
    logic [AW:0]       cap;
    logic [AW-1:0]     mask;
    logic              over_load;
    logic [1:0]        rd_st;
    logic [KEY_W-1:0]  rd_key;
    logic [VB-1:0]     rd_val;
    logic              hit, last;
    logic              we;
    logic [AW-1:0]     wa;
    logic [RW-1:0]     wd;

    assign {q_mode, q_key, q_val, q_home} = i_q_data;
    assign {rd_st, rd_key, rd_val} = r_rd;

    // Derive capacity, mask and load limit
    assign lg   = (i_cap_log2 == '0) ? CFG_W'(1) : i_cap_log2;
    assign pow  = 17'd1 << lg;
    assign cap  = (pow > 17'(MAX_SLOTS)) ? (AW+1)'(MAX_SLOTS) : pow[AW:0];
    assign mask = AW'(cap - 1'b1);
    assign over_load = (20'(r_cnt) * 20'd4) > (20'(cap) * 20'd3);

    assign hit  = (rd_st == SLOT_LIVE) && (rd_key == r_key);
    assign last = (r_i + 1'b1) == cap;
    assign o_pop = (r_st == S_IDLE) && i_q_valid && !r_out_valid;

    always_comb begin
        n_st        = r_st;
        n_sw        = r_sw;
        n_sw_emit   = r_sw_emit;
        n_mode      = r_mode;
        n_key       = r_key;
        n_val       = r_val;
        n_idx       = r_idx;
        n_i         = r_i;
        n_has_tomb  = r_has_tomb;
        n_tomb      = r_tomb;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_vout      = r_vout;
        we = 1'b0;
        wa = r_idx;
        wd = {SLOT_EMPTY, r_key, r_val};
        unique case (r_st)
            S_SWEEP: begin
                // Empty one slot per cycle
                we = 1'b1;
                wa = r_sw;
                if (r_sw == AW'(MAX_SLOTS - 1)) begin
                    n_st = S_IDLE;
                    if (r_sw_emit) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_OK;
                        n_vout      = '0;
                    end
                end else begin
                    n_sw = r_sw + 1'b1;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_mode = q_mode;
                    n_key  = q_key;
                    n_val  = q_val;
                    n_idx  = q_home & mask;
                    n_i    = '0;
                    n_has_tomb = 1'b0;
                    n_vout = '0;
                    if (q_mode == MODE_CLEAR) begin
                        n_cnt     = '0;
                        n_sw      = '0;
                        n_sw_emit = 1'b1;
                        n_st      = S_SWEEP;
                    end else if (q_mode == MODE_PUT && over_load) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_REFUSED;
                    end else begin
                        n_st = S_READ;
                    end
                end
            end
            S_READ: begin
                n_st = S_CHECK;
            end
            S_CHECK: begin
                n_st = S_READ;
                if (r_mode == MODE_PUT) begin
                    if (hit) begin
                        // Update present key
                        we = 1'b1;
                        wd = {SLOT_LIVE, r_key, r_val};
                        n_out_valid = 1'b1;
                        n_status = ST_OK;
                        n_st = S_IDLE;
                    end else if (rd_st == SLOT_EMPTY || (last && (r_has_tomb ||
                                 rd_st == SLOT_TOMB))) begin
                        // Insert at first tombstone or this slot
                        we = 1'b1;
                        wa = r_has_tomb ? r_tomb : r_idx;
                        wd = {SLOT_LIVE, r_key, r_val};
                        n_cnt = r_cnt + 1'b1;
                        n_out_valid = 1'b1;
                        n_status = ST_INSERTED;
                        n_st = S_IDLE;
                    end else if (last) begin
                        n_out_valid = 1'b1;
                        n_status = ST_FULL;
                        n_st = S_IDLE;
                    end else if (rd_st == SLOT_TOMB && !r_has_tomb) begin
                        n_has_tomb = 1'b1;
                        n_tomb = r_idx;
                    end
                end else begin
                    if (hit) begin
                        n_out_valid = 1'b1;
                        n_status = ST_OK;
                        n_st = S_IDLE;
                        if (r_mode == MODE_LOOKUP) begin
                            n_vout = rd_val;
                        end else begin
                            we = 1'b1;
                            wd = {SLOT_TOMB, r_key, VB'(0)};
                            if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                        end
                    end else if (rd_st == SLOT_EMPTY || last) begin
                        n_out_valid = 1'b1;
                        n_status = ST_MISS;
                        n_st = S_IDLE;
                    end
                end
                // Advance to the next slot
                n_i   = r_i + 1'b1;
                n_idx = (r_idx + 1'b1) & mask;
            end
            default: n_st = S_IDLE;
        endcase
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_i      <= n_i;
        r_tomb   <= n_tomb;
        r_status <= n_status;
        r_vout   <= n_vout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_SWEEP;
            r_sw        <= '0;
            r_sw_emit   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_has_tomb  <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_sw        <= n_sw;
            r_sw_emit   <= n_sw_emit;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_has_tomb  <= n_has_tomb;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_value_out  = r_vout;
    assign o_live_count = LIVE_W'(r_cnt);

    // Live count stays within the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_SLOTS))
        else $error("live count above table size");

    // Only a lookup hit carries a value
    a_vout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_vout == '0))
        else $error("value on non-hit result");

    // No result pending while sweeping
    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SWEEP) |-> !r_out_valid)
        else $error("result held during sweep");

    // Insert raises the count by one
    a_ins_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CHECK && n_status == ST_INSERTED && n_out_valid && !r_out_valid)
        |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("insert did not count");

endmodule
